// ===== hdl/lirs_pkg.sv =====
// shared widths, register indexes and reset values for the linear resampler
// no dependencies; imported by every module of the block
package lirs_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int DIFF_W         = SAMPLE_W + 1;
    localparam int STEP_W         = 34;
    localparam int PHASE_W        = 35;
    localparam int CFG_W          = STEP_W;
    localparam int CFG_INDEX_W    = 1;
    localparam int MAX_OUT        = 7;
    localparam int COUNT_W        = 3;
    localparam int FRAC_BITS_DEF  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MONO_MODE  = 1'd1;

    localparam logic [STEP_W-1:0] STEP_RESET = 34'h1_0000_0000;

    localparam logic signed [SAMPLE_W+1:0] SAT_MAX = 18'sd32767;
    localparam logic signed [SAMPLE_W+1:0] SAT_MIN = -18'sd32768;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_prev;
        logic settle;
        logic capture;
        logic mul;
        logic load_out;
        logic retire;
    } lirs_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic primed;
        logic whole_zero;
        logic next_whole_zero;
    } lirs_status_t;

endpackage

// ===== hdl/linear_interp_resampler.sv =====
// top level of the linear interpolation resampler
// depends on lirs_pkg, lirs_ctrl and lirs_datapath
//
//  channel   signals                                  request
//  input     in_valid, in_stall, left/right_sample    one stereo or mono sample pair
//  output    out_valid, out_stall, left/right_out     one interpolated pair, last marks the end
//  config    cfg_we, cfg_index, cfg_data              one register write, no wait
//
// an input request is taken while the controller is idle; one that emits nothing is done as it is taken
// each output pair then goes through multiply (MUL), add and saturate (ADD) and present (WAIT),
// so an input with pairs to emit holds the input side until its last pair, plus any output stall
// these steps per pair follow from the registered multiplier ahead of the adder
// reset is asynchronous and active low; no clearing pass, the block is ready at once
// in_stall stays high while pairs of the current request are still being delivered
module linear_interp_resampler
    import lirs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration write port
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    // input samples
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] left_sample,
    input  logic signed [SAMPLE_W-1:0] right_sample,
    // output samples
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] left_out,
    output logic signed [SAMPLE_W-1:0] right_out,
    output logic                       last
);

    lirs_cmd_t    cmd;
    lirs_status_t status;

    // sequencing: accept, per pair multiply/add/present, then retire
    lirs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .last      (last)
    );

    // phase accumulator, sample history and the two interpolation lanes
    lirs_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .cmd          (cmd),
        .status       (status),
        .left_out     (left_out),
        .right_out    (right_out)
    );

endmodule

// ===== hdl/lirs_ctrl.sv =====
// controller state machine of the linear resampler
// depends on lirs_pkg for the command and status structs
module lirs_ctrl
    import lirs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         out_stall,
    input  lirs_status_t status,
    output lirs_cmd_t    cmd,
    output logic         in_stall,
    output logic         out_valid,
    output logic         last
);

    typedef enum logic [1:0] {
        IDLE,
        MUL,
        ADD,
        WAIT
    } state_t;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               valid_reg, valid_next;
    logic               last_reg, last_next;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        valid_next = valid_reg;
        last_next  = last_reg;
        cmd        = '0;
        case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    if (!status.primed)
                    begin
                        cmd.load_prev = 1'b1;
                    end
                    else if (!status.whole_zero)
                    begin
                        // whole position pending: consume it, emit nothing
                        cmd.load_prev = 1'b1;
                        cmd.settle    = 1'b1;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        count_next  = '0;
                        state_next  = MUL;
                    end
                end
            end
            MUL:
            begin
                cmd.mul    = 1'b1;
                last_next  = (count_reg == COUNT_W'(MAX_OUT - 1)) || !status.next_whole_zero;
                count_next = count_reg + COUNT_W'(1);
                state_next = ADD;
            end
            ADD:
            begin
                cmd.load_out = 1'b1;
                valid_next   = 1'b1;
                state_next   = WAIT;
            end
            WAIT:
            begin
                if (!out_stall)
                begin
                    valid_next = 1'b0;
                    if (last_reg)
                    begin
                        cmd.retire = 1'b1;
                        state_next = IDLE;
                    end
                    else
                    begin
                        state_next = MUL;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            count_reg <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    assign in_stall  = (state_reg != IDLE);
    assign out_valid = valid_reg;
    assign last      = last_reg;

endmodule

// ===== hdl/lirs_datapath.sv =====
// datapath of the linear resampler: registers, phase, multipliers, saturation
// depends on lirs_pkg; driven by lirs_ctrl through lirs_cmd_t
module lirs_datapath
    import lirs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic signed [SAMPLE_W-1:0] left_sample,
    input  logic signed [SAMPLE_W-1:0] right_sample,
    input  lirs_cmd_t                  cmd,
    output lirs_status_t               status,
    output logic signed [SAMPLE_W-1:0] left_out,
    output logic signed [SAMPLE_W-1:0] right_out
);

    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
    localparam logic [PHASE_W-1:0] ONE_POS = PHASE_W'(1) << FRAC_BITS;

    logic [STEP_W-1:0]          step_reg;
    logic                       mono_reg;
    logic [PHASE_W-1:0]         phase_reg, phase_next;
    logic                       primed_reg;
    logic signed [SAMPLE_W-1:0] prev_l_reg, prev_r_reg;
    logic signed [SAMPLE_W-1:0] cur_l_reg, cur_r_reg;
    logic signed [PROD_W-1:0]   prod_l_reg, prod_r_reg;
    logic signed [SAMPLE_W-1:0] out_l_reg, out_r_reg;

    logic signed [SAMPLE_W-1:0] in_r;
    logic [PHASE_W-1:0]         phase_adv;
    logic signed [FRAC_BITS:0]  frac;
    logic signed [DIFF_W-1:0]   diff_l, diff_r;
    logic signed [PROD_W-1:0]   prod_l_next, prod_r_next;
    logic signed [PROD_W-1:0]   sh_l, sh_r;
    logic signed [SAMPLE_W+1:0] sum_l, sum_r;
    logic signed [SAMPLE_W-1:0] sat_l, sat_r;

    function automatic logic signed [SAMPLE_W-1:0] saturate(logic signed [SAMPLE_W+1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > SAT_MAX)
        begin
            r = SAT_MAX[SAMPLE_W-1:0];
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    assign in_r      = mono_reg ? left_sample : right_sample;
    assign phase_adv = phase_reg + PHASE_W'(step_reg);
    assign frac      = $signed({1'b0, phase_reg[FRAC_BITS-1:0]});

    // s0 + (s1 - s0) * frac, floored: same as the offset blend
    assign diff_l      = DIFF_W'(cur_l_reg) - DIFF_W'(prev_l_reg);
    assign diff_r      = DIFF_W'(cur_r_reg) - DIFF_W'(prev_r_reg);
    assign prod_l_next = diff_l * frac;
    assign prod_r_next = diff_r * frac;

    assign sh_l  = prod_l_reg >>> FRAC_BITS;
    assign sh_r  = prod_r_reg >>> FRAC_BITS;
    assign sum_l = (SAMPLE_W+2)'(prev_l_reg) + $signed(sh_l[SAMPLE_W+1:0]);
    assign sum_r = (SAMPLE_W+2)'(prev_r_reg) + $signed(sh_r[SAMPLE_W+1:0]);
    assign sat_l = saturate(sum_l);
    assign sat_r = saturate(sum_r);

    always_comb
    begin
        phase_next = phase_reg;
        if (cmd.settle || cmd.retire)
        begin
            if (phase_reg[PHASE_W-1:FRAC_BITS] != '0)
            begin
                phase_next = phase_reg - ONE_POS;
            end
            else
            begin
                phase_next = '0;
            end
        end
        else if (cmd.mul)
        begin
            phase_next = phase_adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= STEP_RESET;
            mono_reg   <= 1'b0;
            phase_reg  <= '0;
            primed_reg <= 1'b0;
            prev_l_reg <= '0;
            prev_r_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PHASE_STEP: step_reg <= cfg_data;
                REG_MONO_MODE:  mono_reg <= cfg_data[0];
                default:        step_reg <= step_reg;
            endcase
            phase_reg  <= '0;
            primed_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (cmd.load_prev)
            begin
                prev_l_reg <= left_sample;
                prev_r_reg <= in_r;
                primed_reg <= 1'b1;
            end
            else if (cmd.retire)
            begin
                prev_l_reg <= cur_l_reg;
                prev_r_reg <= cur_r_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cur_l_reg <= left_sample;
            cur_r_reg <= in_r;
        end
        if (cmd.mul)
        begin
            prod_l_reg <= prod_l_next;
            prod_r_reg <= prod_r_next;
        end
        if (cmd.load_out)
        begin
            out_l_reg <= sat_l;
            out_r_reg <= sat_r;
        end
    end

    assign status.primed          = primed_reg;
    assign status.whole_zero      = (phase_reg[PHASE_W-1:FRAC_BITS] == '0);
    assign status.next_whole_zero = (phase_adv[PHASE_W-1:FRAC_BITS] == '0);

    assign left_out  = out_l_reg;
    assign right_out = out_r_reg;

endmodule
